>>> hw/rtl/v3alu_pkg.sv
// Package for the 3D vector fixed point ALU: opcodes, status codes, widths.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package v3alu_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int FIELD_BITS    = 32;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_SCALE = 3'd2;
   localparam logic [2:0] OP_DIV   = 3'd3;
   localparam logic [2:0] OP_MAG   = 3'd4;
   localparam logic [2:0] OP_NORM  = 3'd5;
   localparam logic [2:0] OP_CROSS = 3'd6;
   localparam logic [2:0] OP_DOT   = 3'd7;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_DZ  = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] a_x;
      logic [31:0] a_y;
      logic [31:0] a_z;
      logic [31:0] b_x;
      logic [31:0] b_y;
      logic [31:0] b_z;
      logic [31:0] scalar_k;
   } req_type;

   typedef struct packed {
      logic [31:0] res_x;
      logic [31:0] res_y;
      logic [31:0] res_z;
      logic [31:0] res_scalar;
      logic [1:0]  status;
   } rsp_type;

endpackage

>>> hw/rtl/v3alu_if.sv
// Valid/ready stream interface carrying one payload struct.
// Depends on v3alu_pkg for the payload types.
`timescale 1ns / 1ps

interface v3alu_req_if;
   logic               valid;
   logic               ready;
   v3alu_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface v3alu_rsp_if;
   logic               valid;
   logic               ready;
   v3alu_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vector3_fixed_point_alu_core.sv
// Top level of the 3D vector fixed point ALU.
// Depends on v3alu_pkg and the stream interfaces in v3alu_if.sv.
`timescale 1ns / 1ps
//
// Usage: items enter on req (opcode, vectors A and B, scalar k) and one
// result per item leaves on rsp (vector, scalar, status). A transfer happens
// when valid and ready are both high at a rising clock edge.
// The datapath is a stall-able pipeline: stage 0 forms every product, stage 1
// sums and rounds, 32 stages produce the square root one bit each, one stage
// sets up the division, 33 + FRAC_BITS stages retire one quotient bit each,
// and a last stage applies signs. Throughput is one item per cycle while the
// pipeline is not stalled. Reset (synchronous, active high) clears all valid
// bits; no results are pending afterwards. When the last stage holds a result
// and rsp.ready is low, the whole pipeline freezes in place and req.ready is
// low in the same cycle, so nothing is lost or repeated.
//
module vector3_fixed_point_alu_core #(
   parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   v3alu_req_if.sink   req,
   v3alu_rsp_if.source rsp
);

   localparam int RB  = (WORD_BITS < v3alu_pkg::FIELD_BITS) ? WORD_BITS
                                                           : v3alu_pkg::FIELD_BITS;
   // Dividend a*2^F fits below 2^(32+F); quotient needs QB bits.
   localparam int QB  = 33 + FRAC_BITS;
   localparam int DB  = 34;              // divisor magnitude width
   localparam int RTB = 32;              // root bits for a 64-bit radicand
   localparam int DEPTH = 4 + RTB + QB;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] a0, a1, a2;
      logic signed [31:0] k;
      logic signed [63:0] p0, p1, p2, p3, p4, p5;   // exact products
      logic signed [65:0] s0, s1, s2;   // unsaturated results, products rounded
      logic [RTB-1:0]     rt;           // root bits
      logic [65:0]        rem;          // radicand, then root remainder
      logic [DB-1:0]      dv;           // divisor magnitude
      logic               dneg;
      logic [QB-1:0]      q0, q1, q2;   // quotient magnitudes
      logic [DB:0]        r0, r1, r2;   // partial remainders
      logic [QB-1:0]      n0, n1, n2;   // dividend magnitudes
      logic               ng0, ng1, ng2;
   } st_type;

   st_type   pd_ff  [DEPTH];
   logic     pv_ff  [DEPTH];
   logic     adv;

   assign adv       = !pv_ff[DEPTH-1] || rsp.ready;
   assign req.ready = adv;

   function automatic logic signed [65:0] rnd(input logic signed [65:0] v);
      rnd = (v + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // Valid bits travel with the data and only move when the tail frees.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) pv_ff[i] <= 1'b0;
      end else if (adv) begin
         pv_ff[0] <= req.valid;
         for (int i = 1; i < DEPTH; i++) pv_ff[i] <= pv_ff[i-1];
      end
   end

   // Pipeline datapath.
   always_ff @(posedge clock) begin
      st_type t;
      logic signed [31:0] ax, ay, az, bx, by, bz, kk;
      logic [65:0] trial, cur;
      logic [DB:0] rr;
      logic [31:0] m;
      logic [32:0] ka, am0, am1, am2;
      int j;
      if (adv) begin
         // Stage 0: capture, form every needed product, and the add/sub sums.
         ax = $signed(req.data.a_x); ay = $signed(req.data.a_y);
         az = $signed(req.data.a_z);
         bx = $signed(req.data.b_x); by = $signed(req.data.b_y);
         bz = $signed(req.data.b_z);
         kk = $signed(req.data.scalar_k);
         t = '0;
         t.op = req.data.opcode;
         t.a0 = ax; t.a1 = ay; t.a2 = az;
         t.k  = kk;
         case (req.data.opcode)
            v3alu_pkg::OP_ADD: begin
               t.s0 = 66'(ax) + 66'(bx);
               t.s1 = 66'(ay) + 66'(by);
               t.s2 = 66'(az) + 66'(bz);
            end
            v3alu_pkg::OP_SUB: begin
               t.s0 = 66'(ax) - 66'(bx);
               t.s1 = 66'(ay) - 66'(by);
               t.s2 = 66'(az) - 66'(bz);
            end
            v3alu_pkg::OP_SCALE: begin
               t.p0 = ax * kk; t.p1 = ay * kk; t.p2 = az * kk;
            end
            v3alu_pkg::OP_CROSS: begin
               t.p0 = ay * bz; t.p1 = by * az;
               t.p2 = az * bx; t.p3 = bz * ax;
               t.p4 = ax * by; t.p5 = bx * ay;
            end
            v3alu_pkg::OP_DOT: begin
               t.p0 = ax * bx; t.p1 = ay * by; t.p2 = az * bz;
            end
            default: begin
               t.p0 = ax * ax; t.p1 = ay * ay; t.p2 = az * az;
            end
         endcase
         pd_ff[0] <= t;

         // Stage 1: sums and rounding.
         t = pd_ff[0];
         case (t.op)
            v3alu_pkg::OP_SCALE: begin
               t.s0 = rnd(66'(t.p0)); t.s1 = rnd(66'(t.p1)); t.s2 = rnd(66'(t.p2));
            end
            v3alu_pkg::OP_CROSS: begin
               t.s0 = rnd(66'(t.p0) - 66'(t.p1));
               t.s1 = rnd(66'(t.p2) - 66'(t.p3));
               t.s2 = rnd(66'(t.p4) - 66'(t.p5));
            end
            v3alu_pkg::OP_DOT: t.s0 = rnd(66'(t.p0) + 66'(t.p1) + 66'(t.p2));
            v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
               t.rem = 66'(t.p0) + 66'(t.p1) + 66'(t.p2);
            end
            default: ;
         endcase
         t.p0 = '0; t.p1 = '0; t.p2 = '0; t.p3 = '0; t.p4 = '0; t.p5 = '0;
         pd_ff[1] <= t;

         // Square root, one result bit per stage (pairs from the top).
         for (int i = 0; i < RTB; i++) begin
            t = pd_ff[1 + i];
            cur   = t.rem >> (2 * (RTB - 1 - i));
            trial = 66'({t.rt, 2'b01});
            if (cur >= trial) begin
               t.rem = t.rem - (trial << (2 * (RTB - 1 - i)));
               t.rt  = {t.rt[RTB-2:0], 1'b1};
            end else begin
               t.rt  = {t.rt[RTB-2:0], 1'b0};
            end
            pd_ff[2 + i] <= t;
         end

         // Division setup: round the root, set the magnitude result, pick divisor and dividends.
         t = pd_ff[1 + RTB];
         m  = t.rt + ((t.rem > 66'(t.rt)) ? 32'd1 : 32'd0);
         ka = t.k[31] ? 33'(-34'(t.k)) : {1'b0, t.k};
         if (t.op == v3alu_pkg::OP_MAG) t.s0 = 66'({1'b0, m});
         if (t.op == v3alu_pkg::OP_NORM) begin
            t.dv = DB'(m); t.dneg = 1'b0;
         end else begin
            t.dv = DB'(ka); t.dneg = t.k[31];
         end
         t.ng0 = t.a0[31]; t.ng1 = t.a1[31]; t.ng2 = t.a2[31];
         am0 = t.a0[31] ? 33'(-34'(t.a0)) : {1'b0, t.a0};
         am1 = t.a1[31] ? 33'(-34'(t.a1)) : {1'b0, t.a1};
         am2 = t.a2[31] ? 33'(-34'(t.a2)) : {1'b0, t.a2};
         t.n0 = (QB'(am0) << FRAC_BITS) + QB'(t.dv >> 1);
         t.n1 = (QB'(am1) << FRAC_BITS) + QB'(t.dv >> 1);
         t.n2 = (QB'(am2) << FRAC_BITS) + QB'(t.dv >> 1);
         t.r0 = '0; t.r1 = '0; t.r2 = '0; t.q0 = '0; t.q1 = '0; t.q2 = '0;
         pd_ff[2 + RTB] <= t;

         // Restoring divider, one quotient bit per stage for all lanes.
         for (int i = 0; i < QB; i++) begin
            t = pd_ff[2 + RTB + i];
            j = QB - 1 - i;
            rr = {t.r0[DB-1:0], t.n0[j]};
            if (rr >= {1'b0, t.dv}) begin t.r0 = rr - {1'b0, t.dv}; t.q0[j] = 1'b1; end
            else t.r0 = rr;
            rr = {t.r1[DB-1:0], t.n1[j]};
            if (rr >= {1'b0, t.dv}) begin t.r1 = rr - {1'b0, t.dv}; t.q1[j] = 1'b1; end
            else t.r1 = rr;
            rr = {t.r2[DB-1:0], t.n2[j]};
            if (rr >= {1'b0, t.dv}) begin t.r2 = rr - {1'b0, t.dv}; t.q2[j] = 1'b1; end
            else t.r2 = rr;
            pd_ff[3 + RTB + i] <= t;
         end

         // Final stage: select and sign the quotients, or pass A through for a zero-length norm.
         t = pd_ff[2 + RTB + QB];
         if ((t.op == v3alu_pkg::OP_DIV && t.dv != '0) ||
             (t.op == v3alu_pkg::OP_NORM && t.rt != '0)) begin
            t.s0 = (t.ng0 ^ t.dneg) ? -66'(t.q0) : 66'(t.q0);
            t.s1 = (t.ng1 ^ t.dneg) ? -66'(t.q1) : 66'(t.q1);
            t.s2 = (t.ng2 ^ t.dneg) ? -66'(t.q2) : 66'(t.q2);
         end else if (t.op == v3alu_pkg::OP_NORM) begin
            t.s0 = 66'(t.a0); t.s1 = 66'(t.a1); t.s2 = 66'(t.a2);
         end
         pd_ff[DEPTH-1] <= t;
      end
   end

   // Output formatting from the last stage.
   always_comb begin
      st_type t;
      logic signed [65:0] hi, lo, v [4];
      logic ov, dz;
      t  = pd_ff[DEPTH-1];
      hi = (66'sd1 <<< (RB - 1)) - 66'sd1;
      lo = -hi - 66'sd1;
      ov = 1'b0;
      dz = (t.op == v3alu_pkg::OP_DIV) && (t.k == 32'sd0);
      v[0] = '0; v[1] = '0; v[2] = '0; v[3] = '0;
      case (t.op)
         v3alu_pkg::OP_MAG, v3alu_pkg::OP_DOT: v[3] = t.s0;
         default: begin v[0] = t.s0; v[1] = t.s1; v[2] = t.s2; end
      endcase
      if (dz) begin
         v[0] = t.a0[31] ? lo : (t.a0 != 0 ? hi : '0);
         v[1] = t.a1[31] ? lo : (t.a1 != 0 ? hi : '0);
         v[2] = t.a2[31] ? lo : (t.a2 != 0 ? hi : '0);
      end
      for (int i = 0; i < 4; i++) begin
         if (v[i] > hi) begin v[i] = hi; ov = 1'b1; end
         if (v[i] < lo) begin v[i] = lo; ov = 1'b1; end
      end
      rsp.data.res_x      = v[0][31:0];
      rsp.data.res_y      = v[1][31:0];
      rsp.data.res_z      = v[2][31:0];
      rsp.data.res_scalar = v[3][31:0];
      rsp.data.status     = dz ? v3alu_pkg::ST_DZ
                               : (ov ? v3alu_pkg::ST_OVF : v3alu_pkg::ST_OK);
   end

   assign rsp.valid = pv_ff[DEPTH-1];

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("result dropped during stall");
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.data))
      else $error("result changed during stall");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(pv_ff[0]))
      else $error("pipeline moved while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with empty tail");
`endif

endmodule
